@@ design/psf_pkg.sv @@
// Shared types and constants for the polygon scanline fill unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package psf_pkg;

  parameter int MaxVerticesDef = 32;
  parameter int MaxEdgesDef    = 32;
  parameter int SpanCap        = 16;
  parameter int SpanCntW       = 5;    // holds 0..SpanCap
  parameter int CoordW         = 10;
  parameter int PixW           = 11;
  parameter int FixW           = 32;
  parameter int ColorW         = 16;
  parameter int TopW           = 11;   // top y with one extra bit for the wrap below zero
  parameter int DivW           = 26;   // |dx| << 16

  typedef struct packed {
    logic [CoordW-1:0] low_y;
    logic [TopW-1:0]   top_y;
    logic [FixW-1:0]   x_fixed;
    logic [FixW-1:0]   slope_fixed;
  } edge_t;

  // edge table write from the builder
  typedef struct packed {
    logic  we;
    logic  clr;    // discard all active bits
    edge_t data;
  } edge_wr_t;

  typedef struct packed {
    logic [CoordW-1:0] span_y;
    logic [PixW-1:0]   x_start;
    logic [PixW-1:0]   x_end;
    logic [ColorW-1:0] span_color;
    logic              no_span;
    logic              last_span;
  } span_t;

endpackage

@@ design/psf_div.sv @@
// Iterative restoring divider for edge slopes: (dx << 16) / dy, one bit a cycle.
// Depends on psf_pkg.
`timescale 1ns / 1ps

module psf_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [psf_pkg::CoordW-1:0] mag_i,
  input  logic                      neg_i,
  input  logic [psf_pkg::CoordW-1:0] dvs_i,
  output logic                      done_o,
  output logic [psf_pkg::FixW-1:0]  quo_o
);
  import psf_pkg::*;

  localparam int CntW = $clog2(DivW);

  logic [DivW-1:0]   num_q;
  logic [CoordW:0]   rem_q;
  logic [CoordW-1:0] dvs_q;
  logic              neg_q, busy_q, done_q;
  logic [CntW-1:0]   cnt_q;
  logic [CoordW:0]   rem_sh, rem_sub;
  logic              qbit;

  always_comb begin
    rem_sh  = {rem_q[CoordW-1:0], num_q[DivW-1]};
    qbit    = (rem_sh >= {1'b0, dvs_q});
    rem_sub = qbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {mag_i, 16'h0000};
      rem_q <= '0;
      dvs_q <= dvs_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      num_q <= {num_q[DivW-2:0], qbit};
      rem_q <= rem_sub;
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? (FixW'(0) - FixW'(num_q)) : FixW'(num_q);

endmodule

@@ design/psf_vtx_build.sv @@
// Vertex store and edge builder: walks the vertex ring, finds the top adjustment
// and divides out each slope. Depends on psf_pkg and psf_div.
`timescale 1ns / 1ps

module psf_vtx_build #(
  parameter int MaxVertices = psf_pkg::MaxVerticesDef,
  parameter int MaxEdges    = psf_pkg::MaxEdgesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  logic [psf_pkg::CoordW-1:0]        x_i,
  input  logic [psf_pkg::CoordW-1:0]        y_i,
  input  logic                              last_i,
  output logic                              idle_o,
  output psf_pkg::edge_wr_t                 ewr_o,
  output logic [$clog2(MaxEdges)-1:0]       ewaddr_o,
  output logic [$clog2(MaxEdges+1)-1:0]     edge_count_o
);
  import psf_pkg::*;

  localparam int VIW = $clog2(MaxVertices);
  localparam int VCW = $clog2(MaxVertices + 1);
  localparam int EIW = $clog2(MaxEdges);
  localparam int ECW = $clog2(MaxEdges + 1);

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_RA   = 7'b0000010,
    B_RB   = 7'b0000100,
    B_CMP  = 7'b0001000,
    B_WALK = 7'b0010000,
    B_WCHK = 7'b0100000,
    B_DIV  = 7'b1000000
  } bstate_e;

  bstate_e state_q, state_d;

  logic [2*CoordW-1:0] vmem [MaxVertices];
  logic [2*CoordW-1:0] vrd_q;
  logic [VIW-1:0]      raddr;
  logic                vwe;

  logic [VCW-1:0]    vcnt_q, vcnt_d, n_q, n_d, step_q, step_d;
  logic [VIW-1:0]    i_q, i_d, a_q, a_d, k_q, k_d, k_next;
  logic [CoordW-1:0] xa_q, xa_d, ya_q, ya_d, xlo_q, xlo_d, ylo_q, ylo_d, yup_q, yup_d;
  logic [CoordW-1:0] dmag_q, dmag_d, xb, yb, xup, comp;
  logic              dneg_q, dneg_d, dir_q, dir_d;
  logic [TopW-1:0]   top_q, top_d;
  logic [ECW-1:0]    ec_q, ec_d;
  logic              div_start, div_done, last_i_vtx, clr;
  logic [FixW-1:0]   quo;

  assign vwe = load_i && (state_q == B_IDLE) && (vcnt_q < VCW'(MaxVertices));

  always_ff @(posedge clk_i) begin
    if (vwe) begin
      vmem[vcnt_q[VIW-1:0]] <= {y_i, x_i};
    end
    vrd_q <= vmem[raddr];
  end

  assign xb = vrd_q[CoordW-1:0];
  assign yb = vrd_q[2*CoordW-1:CoordW];
  assign last_i_vtx = (VCW'(i_q) + VCW'(1)) == n_q;

  always_comb begin
    if (dir_q) begin
      k_next = (VCW'(k_q) == n_q - VCW'(1)) ? '0 : k_q + 1'b1;
    end else begin
      k_next = (k_q == '0) ? VIW'(n_q - VCW'(1)) : k_q - 1'b1;
    end
  end

  psf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .mag_i  (dmag_q),
    .neg_i  (dneg_q),
    .dvs_i  (yup_q - ylo_q),
    .done_o (div_done),
    .quo_o  (quo)
  );

  always_comb begin
    state_d = state_q;
    vcnt_d = vcnt_q; n_d = n_q; step_d = step_q;
    i_d = i_q; a_d = a_q; k_d = k_q;
    xa_d = xa_q; ya_d = ya_q; xlo_d = xlo_q; ylo_d = ylo_q; yup_d = yup_q;
    dmag_d = dmag_q; dneg_d = dneg_q; dir_d = dir_q; top_d = top_q; ec_d = ec_q;
    raddr = '0;
    div_start = 1'b0;
    clr = 1'b0;
    xup = '0;
    comp = yup_q;
    ewr_o.we = 1'b0;
    ewr_o.clr = 1'b0;
    ewr_o.data.low_y = ylo_q;
    ewr_o.data.top_y = top_q;
    ewr_o.data.x_fixed = {{(FixW-16-CoordW){1'b0}}, xlo_q, 16'h0000};
    ewr_o.data.slope_fixed = quo;
    case (state_q)
      B_IDLE: begin
        if (load_i) begin
          if (vwe) vcnt_d = vcnt_q + 1'b1;
          if (last_i) begin
            n_d    = vwe ? vcnt_q + 1'b1 : vcnt_q;
            vcnt_d = '0;
            ec_d   = '0;
            clr    = 1'b1;
            i_d    = '0;
            if (n_d >= VCW'(2)) state_d = B_RA;
          end
        end
      end
      B_RA: begin
        a_d     = (i_q == '0) ? VIW'(n_q - VCW'(1)) : i_q - 1'b1;
        raddr   = a_d;
        state_d = B_RB;
      end
      B_RB: begin
        xa_d    = xb;
        ya_d    = yb;
        raddr   = i_q;
        state_d = B_CMP;
      end
      B_CMP: begin
        if (ya_q == yb || ec_q == ECW'(MaxEdges)) begin
          if (last_i_vtx) state_d = B_IDLE;
          else begin
            i_d = i_q + 1'b1;
            state_d = B_RA;
          end
        end else begin
          dir_d = ya_q < yb;
          if (dir_d) begin
            xlo_d = xa_q; ylo_d = ya_q; xup = xb; yup_d = yb; k_d = i_q;
          end else begin
            xlo_d = xb; ylo_d = yb; xup = xa_q; yup_d = ya_q; k_d = a_q;
          end
          dneg_d  = xup < xlo_d;
          dmag_d  = dneg_d ? (xlo_d - xup) : (xup - xlo_d);
          step_d  = VCW'(1);
          state_d = B_WALK;
        end
      end
      B_WALK: begin
        if (step_q >= n_q) begin
          comp      = yup_q;
          div_start = 1'b1;
          state_d   = B_DIV;
        end else begin
          k_d     = k_next;
          raddr   = k_next;
          state_d = B_WCHK;
        end
      end
      B_WCHK: begin
        if (yb != yup_q) begin
          comp      = yb;
          div_start = 1'b1;
          state_d   = B_DIV;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = B_WALK;
        end
      end
      B_DIV: begin
        if (div_done) begin
          ewr_o.we = 1'b1;
          ec_d = ec_q + 1'b1;
          if (last_i_vtx) state_d = B_IDLE;
          else begin
            i_d = i_q + 1'b1;
            state_d = B_RA;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
    // top y drops by one when the neighbor beyond the upper end keeps rising
    if (div_start) begin
      top_d = (yup_q < comp) ? ({1'b0, yup_q} - TopW'(1)) : {1'b0, yup_q};
    end
    ewr_o.clr = clr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      vcnt_q  <= '0;
      ec_q    <= '0;
    end else begin
      state_q <= state_d;
      vcnt_q  <= vcnt_d;
      ec_q    <= ec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; step_q <= step_d; i_q <= i_d; a_q <= a_d; k_q <= k_d;
    xa_q <= xa_d; ya_q <= ya_d; xlo_q <= xlo_d; ylo_q <= ylo_d; yup_q <= yup_d;
    dmag_q <= dmag_d; dneg_q <= dneg_d; dir_q <= dir_d; top_q <= top_d;
  end

  assign idle_o       = (state_q == B_IDLE);
  assign ewaddr_o     = ec_q[EIW-1:0];
  assign edge_count_o = ec_q;

endmodule

@@ design/psf_edge_scan.sv @@
// Edge table memory, active bits, insertion sort row and span output register.
// Depends on psf_pkg.
`timescale 1ns / 1ps

module psf_edge_scan #(
  parameter int MaxEdges = psf_pkg::MaxEdgesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          line_i,
  input  logic [psf_pkg::CoordW-1:0]    cy_i,
  input  logic [psf_pkg::ColorW-1:0]    color_i,
  input  logic [$clog2(MaxEdges+1)-1:0] edge_count_i,
  input  psf_pkg::edge_wr_t             ewr_i,
  input  logic [$clog2(MaxEdges)-1:0]   ewaddr_i,
  output logic                          idle_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output psf_pkg::span_t                out_o
);
  import psf_pkg::*;

  localparam int EIW = $clog2(MaxEdges);
  localparam int ECW = $clog2(MaxEdges + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } sstate_e;

  sstate_e state_q;

  edge_t             emem [MaxEdges];
  edge_t             rd_q, wdata;
  logic [EIW-1:0]    waddr;
  logic              we;
  logic [MaxEdges-1:0] active_q;

  logic [CoordW-1:0] cy_q;
  logic [ECW-1:0]    iss_q, cnt_q;
  logic              pv_q;
  logic [EIW-1:0]    pidx_q;
  logic signed [FixW-1:0] xs_q [MaxEdges];
  logic signed [FixW-1:0] xs_n [MaxEdges];
  logic signed [FixW-1:0] prev [MaxEdges];
  logic [MaxEdges-1:0] gt;
  logic              act, retire, ins, wb_we, issue;
  logic [SpanCntW-1:0] pairs, pi_q;
  logic              oval_q, load, nopair, lastp;
  span_t             out_q, span;
  logic [PixW-1:0]   s_pix, t_pix;

  function automatic logic [PixW-1:0] floor_pix(input logic [FixW-1:0] x);
    logic [FixW-17:0] f;
    f = x[FixW-1:16];
    if (x[FixW-1]) return '0;
    if (f > (FixW-16)'(1024)) return PixW'(1024);
    return PixW'(f);
  endfunction

  function automatic logic [PixW-1:0] ceil_pix(input logic [FixW-1:0] x);
    logic [FixW-1:0] c;
    c = {1'b0, x[FixW-2:0]} + FixW'(16'hFFFF);
    if (x[FixW-1]) return '0;
    if (c[FixW-1:16] > (FixW-16)'(1024)) return PixW'(1024);
    return PixW'(c[FixW-1:16]);
  endfunction

  // scan pass: read edge e, process it once the read is registered and write the stepped x back
  assign issue  = (state_q == S_SCAN) && (iss_q < edge_count_i);
  assign act    = active_q[pidx_q] | (rd_q.low_y == cy_q);
  assign ins    = pv_q & act;
  assign retire = rd_q.top_y <= {1'b0, cy_q};
  assign wb_we  = ins & ~retire;

  always_comb begin
    we    = ewr_i.we | wb_we;
    waddr = ewr_i.we ? ewaddr_i : pidx_q;
    wdata = rd_q;
    wdata.x_fixed = rd_q.x_fixed + rd_q.slope_fixed;
    if (ewr_i.we) wdata = ewr_i.data;
  end

  always_ff @(posedge clk_i) begin
    if (we) emem[waddr] <= wdata;
    rd_q <= emem[iss_q[EIW-1:0]];
  end

  // sorted insertion: equal keys stay behind earlier ones
  always_comb begin
    for (int i = 0; i < MaxEdges; i++) begin
      gt[i] = (ECW'(i) < cnt_q) && (xs_q[i] > $signed(rd_q.x_fixed));
    end
    prev[0] = $signed(rd_q.x_fixed);
    for (int i = 1; i < MaxEdges; i++) prev[i] = xs_q[i-1];
    for (int i = 0; i < MaxEdges; i++) begin
      if (gt[i]) begin
        xs_n[i] = (i > 0 && gt[(i > 0) ? i-1 : 0]) ? prev[i] : $signed(rd_q.x_fixed);
      end else if (ECW'(i) == cnt_q) begin
        xs_n[i] = (i > 0 && gt[(i > 0) ? i-1 : 0]) ? prev[i] : $signed(rd_q.x_fixed);
      end else begin
        xs_n[i] = xs_q[i];
      end
    end
  end

  always_comb begin
    if (32'(cnt_q >> 1) > SpanCap) pairs = SpanCntW'(SpanCap);
    else pairs = SpanCntW'(cnt_q >> 1);
    nopair = (pairs == '0);
    lastp  = nopair || (pi_q + 1'b1 == pairs);
    load   = (state_q == S_EMIT) && (!oval_q || out_ready_i);
    s_pix  = floor_pix(xs_q[0]);
    t_pix  = ceil_pix(xs_q[(MaxEdges > 1) ? 1 : 0]);
    if (t_pix < s_pix) t_pix = s_pix;
    span.span_y     = cy_q;
    span.x_start    = nopair ? '0 : s_pix;
    span.x_end      = nopair ? '0 : t_pix;
    span.span_color = color_i;
    span.no_span    = nopair;
    span.last_span  = lastp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      active_q <= '0;
      pv_q     <= 1'b0;
      oval_q   <= 1'b0;
      iss_q    <= '0;
      cnt_q    <= '0;
      pi_q     <= '0;
    end else begin
      if (ewr_i.clr) active_q <= '0;
      else if (pv_q) active_q[pidx_q] <= act & ~retire;
      pv_q <= issue;
      if (issue) iss_q <= iss_q + 1'b1;
      if (ins) cnt_q <= cnt_q + 1'b1;
      if (load) oval_q <= 1'b1;
      else if (out_ready_i) oval_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (line_i) begin
            iss_q   <= '0;
            cnt_q   <= '0;
            pi_q    <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!issue && !pv_q) state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (load) begin
            pi_q <= pi_q + 1'b1;
            if (lastp) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) pidx_q <= iss_q[EIW-1:0];
    if (line_i && state_q == S_IDLE) cy_q <= cy_i;
    if (ins) begin
      xs_q <= xs_n;
    end else if (load) begin
      for (int i = 0; i + 2 < MaxEdges; i++) xs_q[i] <= xs_q[i+2];
    end
    if (load) out_q <= span;
  end

  assign idle_o      = (state_q == S_IDLE);
  assign out_valid_o = oval_q;
  assign out_o       = out_q;

endmodule

@@ design/polygon_scanline_fill_unit.sv @@
// Top level of the polygon scanline fill unit: stream ports, fill color register.
// Depends on psf_pkg, psf_vtx_build and psf_edge_scan.
`timescale 1ns / 1ps

// Usage:
//   Input requests arrive on s_axis_*. tuser selects the kind: 0 loads one vertex
//   (tdata = x, y), 1 rasterizes the scanline y. tlast on a vertex closes the polygon
//   and builds the edge table. Spans leave on m_axis_*, one request per span pair,
//   or a single no_span request (tuser = 1) for a line without pairs; tlast marks
//   the final span of the line. cfg_we_i writes the fill color reported on spans.
// Sequence:
//   Edge building runs per vertex: vertex memory reads, ring steps searching the
//   neighbor beyond the upper end, and the bit-serial slope divider for every
//   edge built. A scanline makes one pass over the edge memory (read, sort-insert,
//   write back the stepped x), then loads its spans into the output register one
//   at a time.
// Reset clears counts and active bits; the memories hold no defined contents.
// When m_axis_tready is low the span register holds and the unit waits; a new
// request is taken once the last span of the line is in the output register.

module polygon_scanline_fill_unit #(
  parameter int MaxVertices = psf_pkg::MaxVerticesDef,
  parameter int MaxEdges    = psf_pkg::MaxEdgesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // coord_x[9:0], coord_y[19:10], zero pad
  input  logic [0:0]  s_axis_tuser,   // mode
  input  logic        s_axis_tlast,   // last_vertex
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // span_y[9:0], x_start[20:10], x_end[31:21],
                                      // span_color[47:32]
  output logic [0:0]  m_axis_tuser,   // no_span
  output logic        m_axis_tlast    // last_span
);
  import psf_pkg::*;

  logic [ColorW-1:0] color_q;
  logic              acc, b_idle, s_idle;
  edge_wr_t          ewr;
  logic [$clog2(MaxEdges)-1:0]   ewaddr;
  logic [$clog2(MaxEdges+1)-1:0] ecount;
  span_t             span;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) color_q <= '0;
    else if (cfg_we_i) color_q <= cfg_wdata_i;
  end

  assign s_axis_tready = b_idle & s_idle;
  assign acc           = s_axis_tvalid & s_axis_tready;

  psf_vtx_build #(
    .MaxVertices(MaxVertices),
    .MaxEdges   (MaxEdges)
  ) u_build (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (acc & ~s_axis_tuser[0]),
    .x_i         (s_axis_tdata[9:0]),
    .y_i         (s_axis_tdata[19:10]),
    .last_i      (s_axis_tlast),
    .idle_o      (b_idle),
    .ewr_o       (ewr),
    .ewaddr_o    (ewaddr),
    .edge_count_o(ecount)
  );

  psf_edge_scan #(
    .MaxEdges(MaxEdges)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .line_i      (acc & s_axis_tuser[0]),
    .cy_i        (s_axis_tdata[19:10]),
    .color_i     (color_q),
    .edge_count_i(ecount),
    .ewr_i       (ewr),
    .ewaddr_i    (ewaddr),
    .idle_o      (s_idle),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (span)
  );

  assign m_axis_tdata = {span.span_color, span.x_end, span.x_start, span.span_y};
  assign m_axis_tuser = span.no_span;
  assign m_axis_tlast = span.last_span;

endmodule

@@ tb/sv/psf_span_checker.sv @@
// Span checker for the polygon scanline fill unit: predicts spans from accepted requests.
// Depends on psf_pkg; instantiated by tb_top beside the unit.
`timescale 1ns / 1ps

module psf_span_checker
  import psf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          errors_o,
  output int          pending_o
);

  localparam int NumVtx = MaxVerticesDef;
  localparam int NumEdge = MaxEdgesDef;

  // predictor state
  int unsigned vtx_x[NumVtx];
  int unsigned vtx_y[NumVtx];
  int unsigned vtx_cnt;
  int unsigned e_low[NumEdge];
  int unsigned e_top[NumEdge];
  bit [31:0]   e_x[NumEdge];
  bit [31:0]   e_slope[NumEdge];
  bit          e_act[NumEdge];
  int unsigned e_cnt;
  bit [15:0]   color;

  span_t expected_spans[$];

  assign pending_o = expected_spans.size();

  // y of the nearest ring neighbor at a different height
  function automatic int unsigned ring_y(int unsigned n, int unsigned idx, int dir);
    int unsigned k;
    k = idx;
    for (int unsigned st = 1; st < n; st++) begin
      k = (dir > 0) ? (k + 1) % n : (k + n - 1) % n;
      if (vtx_y[k] != vtx_y[idx]) return vtx_y[k];
    end
    return vtx_y[idx];
  endfunction

  task automatic add_edge(int unsigned lo, int unsigned up, int unsigned comp);
    int unsigned top;
    longint dx, dy, q;
    if (e_cnt >= NumEdge) return;
    top = vtx_y[up];
    if (top < comp) top = top - 1;
    dx = longint'(vtx_x[up]) - longint'(vtx_x[lo]);
    dy = longint'(vtx_y[up]) - longint'(vtx_y[lo]);
    q = (dx * 65536) / dy;
    e_low[e_cnt]   = vtx_y[lo];
    e_top[e_cnt]   = top;
    e_x[e_cnt]     = vtx_x[lo] << 16;
    e_slope[e_cnt] = q[31:0];
    e_act[e_cnt]   = 1'b0;
    e_cnt++;
  endtask

  task automatic build_edge_table();
    int unsigned n, a;
    n = vtx_cnt;
    e_cnt = 0;
    foreach (e_act[i]) e_act[i] = 1'b0;
    if (n >= 2) begin
      for (int unsigned i = 0; i < n; i++) begin
        a = (i + n - 1) % n;
        if (vtx_y[a] < vtx_y[i]) add_edge(a, i, ring_y(n, i, 1));
        else if (vtx_y[a] > vtx_y[i]) add_edge(i, a, ring_y(n, a, -1));
      end
    end
    vtx_cnt = 0;
  endtask

  function automatic bit [10:0] pix_floor(longint v);
    if (v < 0) return 0;
    v = v >>> 16;
    return (v > 1024) ? 11'd1024 : v[10:0];
  endfunction

  function automatic bit [10:0] pix_ceil(longint v);
    if (v < 0) return 0;
    v = (v + 16'hFFFF) >>> 16;
    return (v > 1024) ? 11'd1024 : v[10:0];
  endfunction

  task automatic predict_request(bit mode, bit [9:0] cx, bit [9:0] cy, bit lst);
    longint xs[NumEdge];
    longint v;
    int     cnt, pairs, j;
    span_t  sp;
    if (mode == 1'b0) begin
      if (vtx_cnt < NumVtx) begin
        vtx_x[vtx_cnt] = cx;
        vtx_y[vtx_cnt] = cy;
        vtx_cnt++;
      end
      if (lst) build_edge_table();
      return;
    end
    for (int e = 0; e < e_cnt; e++)
      if (e_low[e] == cy) e_act[e] = 1'b1;
    cnt = 0;
    for (int e = 0; e < e_cnt; e++) begin
      if (e_act[e]) begin
        v = longint'($signed(e_x[e]));
        j = cnt;
        while (j > 0 && xs[j-1] > v) begin
          xs[j] = xs[j-1];
          j--;
        end
        xs[j] = v;
        cnt++;
      end
    end
    pairs = cnt / 2;
    if (pairs > SpanCap) pairs = SpanCap;
    sp.span_y = cy;
    sp.span_color = color;
    if (pairs == 0) begin
      sp.x_start = '0;
      sp.x_end = '0;
      sp.no_span = 1'b1;
      sp.last_span = 1'b1;
      expected_spans.push_back(sp);
    end else begin
      for (int i = 0; i < pairs; i++) begin
        sp.x_start = pix_floor(xs[2*i]);
        sp.x_end = pix_ceil(xs[2*i+1]);
        if (sp.x_end < sp.x_start) sp.x_end = sp.x_start;
        sp.no_span = 1'b0;
        sp.last_span = (i + 1 == pairs);
        expected_spans.push_back(sp);
      end
    end
    for (int e = 0; e < e_cnt; e++) begin
      if (e_act[e]) begin
        if (e_top[e] <= cy) e_act[e] = 1'b0;
        else e_x[e] = e_x[e] + e_slope[e];
      end
    end
  endtask

  function automatic void cmp_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: span %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      errors_o++;
    end
  endfunction

  initial begin
    errors_o = 0;
    vtx_cnt = 0;
    e_cnt = 0;
    color = '0;
    foreach (e_act[i]) e_act[i] = 1'b0;
  end

  always @(posedge clk_i) begin
    span_t got, exp_s;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.span_y     = m_axis_tdata[9:0];
        got.x_start    = m_axis_tdata[20:10];
        got.x_end      = m_axis_tdata[31:21];
        got.span_color = m_axis_tdata[47:32];
        got.no_span    = m_axis_tuser[0];
        got.last_span  = m_axis_tlast;
        if (expected_spans.size() == 0) begin
          $display("%0t: unexpected span, expected none, actual %p", $time, got);
          errors_o++;
        end else begin
          exp_s = expected_spans.pop_front();
          cmp_field("span_y", exp_s.span_y, got.span_y);
          cmp_field("x_start", exp_s.x_start, got.x_start);
          cmp_field("x_end", exp_s.x_end, got.x_end);
          cmp_field("span_color", exp_s.span_color, got.span_color);
          cmp_field("no_span", exp_s.no_span, got.no_span);
          cmp_field("last_span", exp_s.last_span, got.last_span);
        end
      end
      if (cfg_we_i) color = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        predict_request(s_axis_tuser[0], s_axis_tdata[9:0], s_axis_tdata[19:10],
                        s_axis_tlast);
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for the polygon scanline fill unit: clock, reset, requests, verdict.
// Depends on psf_pkg, polygon_scanline_fill_unit and psf_span_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int CycleLimit = 3000000;
  localparam int BuildDrain = 4000;  // worst edge build of a full vertex store
  localparam int NumItems = 370;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int errors, pending, cycles, sent, ready_wait;
  bit burst = 1'b0;

  always #5 clk_i = ~clk_i;

  polygon_scanline_fill_unit dut (.*);

  psf_span_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // span sink: random stall before each span
  always @(posedge clk_i) begin
    int w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      ready_wait <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      w = burst ? 0 : $urandom_range(0, 15);
      m_axis_tready <= (w == 0);
      ready_wait <= w;
    end else if (!m_axis_tready) begin
      if (ready_wait <= 1) m_axis_tready <= 1'b1;
      ready_wait <= ready_wait - 1;
    end
  end

  task automatic send(bit mode, bit [9:0] x, bit [9:0] y, bit lst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, y, x};
    s_axis_tuser <= mode;
    s_axis_tlast <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic set_color(bit [15:0] c);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (BuildDrain) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random polygon followed by a sweep of its lines, with stray line requests mixed in
  task automatic run_polygon();
    int n, h, base, ymin, ymax, y;
    bit [9:0] vy;
    burst = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 19))
      0:       n = $urandom_range(30, 35);   // may fill or overrun the vertex store
      1:       n = $urandom_range(1, 2);
      default: n = $urandom_range(3, 8);
    endcase
    h = $urandom_range(1, 12);
    base = ($urandom_range(0, 3) == 0) ? 1023 - h : $urandom_range(0, 1023 - h);
    ymin = 1023;
    ymax = 0;
    for (int i = 0; i < n; i++) begin
      vy = 10'(base + $urandom_range(0, h));
      if (vy < ymin) ymin = vy;
      if (vy > ymax) ymax = vy;
      if ($urandom_range(0, 9) == 0) send(1'b1, 10'($urandom), 10'($urandom), 1'($urandom));
      send(1'b0, 10'($urandom_range(0, 1023)), vy, i == n - 1);
    end
    y = ymin;
    while (y <= ymax + 1 && y <= 1023) begin
      if ($urandom_range(0, 6) == 0)
        send(1'b1, 10'($urandom), 10'($urandom_range(0, 1023)), 1'($urandom));
      else send(1'b1, 10'($urandom), 10'(y), 1'($urandom));
      if ($urandom_range(0, 9) != 0) y++;
    end
  endtask

  initial begin
    cycles = 0;
    sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, wide triangle at the extremes
    send(1'b1, 10'd0, 10'd0, 1'b0);
    send(1'b0, 10'd0, 10'd0, 1'b0);
    send(1'b0, 10'd1023, 10'd0, 1'b0);
    send(1'b0, 10'd512, 10'd1023, 1'b1);
    send(1'b1, 10'd0, 10'd0, 1'b0);
    send(1'b1, 10'd0, 10'd1, 1'b0);
    send(1'b1, 10'd0, 10'd2, 1'b0);
    send(1'b1, 10'd0, 10'd1023, 1'b0);
    set_color(16'hFFFF);
    // one vertex, then a flat polygon: no edges
    send(1'b0, 10'd77, 10'd500, 1'b1);
    send(1'b1, 10'd0, 10'd500, 1'b0);
    send(1'b0, 10'd5, 10'd7, 1'b0);
    send(1'b0, 10'd9, 10'd7, 1'b0);
    send(1'b0, 10'd20, 10'd7, 1'b1);
    send(1'b1, 10'd0, 10'd7, 1'b0);
    // lone edge gives an odd count, repeated line reactivates
    send(1'b0, 10'd100, 10'd20, 1'b0);
    send(1'b0, 10'd200, 10'd40, 1'b0);
    send(1'b0, 10'd150, 10'd60, 1'b1);
    send(1'b1, 10'd0, 10'd40, 1'b0);
    send(1'b1, 10'd0, 10'd20, 1'b0);
    send(1'b1, 10'd0, 10'd20, 1'b0);
    set_color(16'h8001);

    while (sent < NumItems) begin
      if (sent > 150 && sent < 165) set_color(16'h0000);
      if (sent > 260 && sent < 275) set_color(16'($urandom));
      run_polygon();
    end

    s_axis_tvalid <= 1'b0;
    burst = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
design/psf_pkg.sv
design/psf_div.sv
design/psf_vtx_build.sv
design/psf_edge_scan.sv
design/polygon_scanline_fill_unit.sv
tb/sv/psf_span_checker.sv
tb/sv/tb_top.sv
